### design/kdlpr_pkg.sv
`default_nettype none
package kdlpr_pkg;

   localparam int unsigned NUM_KEYS     = 4;
   localparam int unsigned HISTORY_BITS = 8;

   localparam int unsigned INC_BITS   = 8;
   localparam int unsigned TIME_BITS  = 16;
   localparam int unsigned CSR_BITS   = 16;
   localparam int unsigned INDEX_BITS = 3;

   typedef logic [NUM_KEYS-1:0]     key_vec_type;
   typedef logic [HISTORY_BITS-1:0] history_type;
   typedef logic [TIME_BITS-1:0]    time_type;
   typedef logic [INC_BITS-1:0]     inc_type;
   typedef logic [INDEX_BITS-1:0]   csr_index_type;
   typedef logic [CSR_BITS-1:0]     csr_data_type;

   // register indexes of the configuration port
   localparam csr_index_type CSR_HOLD_INCREMENT  = 3'd0;
   localparam csr_index_type CSR_REPEAT_FIRST    = 3'd1;
   localparam csr_index_type CSR_REPEAT_INTERVAL = 3'd2;
   localparam csr_index_type CSR_HOLD_LIMIT      = 3'd3;
   localparam csr_index_type CSR_HOLD_RESTART    = 3'd4;

   localparam inc_type  HOLD_INCREMENT_RESET  = 8'd2;
   localparam time_type REPEAT_FIRST_RESET    = 16'd1000;
   localparam time_type REPEAT_INTERVAL_RESET = 16'd100;
   localparam time_type HOLD_LIMIT_RESET      = 16'd60000;
   localparam time_type HOLD_RESTART_RESET    = 16'd900;

   typedef struct packed {
      inc_type  hold_increment;
      time_type repeat_first;
      time_type repeat_interval;
      time_type hold_limit;
      time_type hold_restart;
   } cfg_type;

   // add with saturation at the top of the time range
   function automatic time_type sat_add(input time_type a, input time_type b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

### design/kdlpr_req_if.sv
`default_nettype none
interface kdlpr_req_if;
   logic                  valid;
   logic                  ready;
   kdlpr_pkg::key_vec_type key_levels;

   modport source (output valid, output key_levels, input ready);
   modport sink (input valid, input key_levels, output ready);
endinterface
`default_nettype wire

### design/kdlpr_rsp_if.sv
`default_nettype none
interface kdlpr_rsp_if;
   logic                  valid;
   logic                  ready;
   kdlpr_pkg::key_vec_type press_mask;
   kdlpr_pkg::key_vec_type repeat_mask;
   kdlpr_pkg::key_vec_type debounced_levels;

   modport source (output valid, output press_mask, output repeat_mask,
                   output debounced_levels, input ready);
   modport sink (input valid, input press_mask, input repeat_mask,
                 input debounced_levels, output ready);
endinterface
`default_nettype wire

### design/key_debounce_long_press_repeat.sv
`default_nettype none
// Key debouncer with press events and long-press auto-repeat for four active-low
// keys. Each transfer on req_chan is one scan tick of raw levels; it yields exactly
// one transfer on rsp_chan with the press events, repeat events and debounced
// levels after that tick. A key is debounced once its last eight samples agree.
// One tick is taken per clock cycle: the per-key history, hold time and threshold
// update in a single pass into the state registers while the result lands in an
// output register, so a new tick is taken even while a result waits, as long as
// the output register is empty or being drained in the same cycle. Each result is
// registered. Configuration writes on the csr_ port apply from the next tick.
module key_debounce_long_press_repeat (
   input  wire                        clock,
   input  wire                        reset,
   kdlpr_req_if.sink                  req_chan,
   kdlpr_rsp_if.source                rsp_chan,
   input  wire                        csr_we,
   input  wire kdlpr_pkg::csr_index_type csr_index,
   input  wire kdlpr_pkg::csr_data_type  csr_wdata
);

   kdlpr_pkg::cfg_type     cfg_ff;
   kdlpr_pkg::history_type hist_ff [kdlpr_pkg::NUM_KEYS];
   kdlpr_pkg::history_type hist_in [kdlpr_pkg::NUM_KEYS];
   kdlpr_pkg::time_type    hold_ff [kdlpr_pkg::NUM_KEYS];
   kdlpr_pkg::time_type    hold_in [kdlpr_pkg::NUM_KEYS];
   kdlpr_pkg::time_type    thr_ff  [kdlpr_pkg::NUM_KEYS];
   kdlpr_pkg::time_type    thr_in  [kdlpr_pkg::NUM_KEYS];
   kdlpr_pkg::key_vec_type level_ff, level_in;
   kdlpr_pkg::key_vec_type press_in, repeat_in;

   kdlpr_pkg::key_vec_type press_ff, repeat_ff, out_level_ff;
   logic                   rsp_valid_ff;
   logic                   req_fire;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_increment  <= kdlpr_pkg::HOLD_INCREMENT_RESET;
         cfg_ff.repeat_first    <= kdlpr_pkg::REPEAT_FIRST_RESET;
         cfg_ff.repeat_interval <= kdlpr_pkg::REPEAT_INTERVAL_RESET;
         cfg_ff.hold_limit      <= kdlpr_pkg::HOLD_LIMIT_RESET;
         cfg_ff.hold_restart    <= kdlpr_pkg::HOLD_RESTART_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kdlpr_pkg::CSR_HOLD_INCREMENT:
               cfg_ff.hold_increment <= csr_wdata[kdlpr_pkg::INC_BITS-1:0];
            kdlpr_pkg::CSR_REPEAT_FIRST:    cfg_ff.repeat_first    <= csr_wdata;
            kdlpr_pkg::CSR_REPEAT_INTERVAL: cfg_ff.repeat_interval <= csr_wdata;
            kdlpr_pkg::CSR_HOLD_LIMIT:      cfg_ff.hold_limit      <= csr_wdata;
            kdlpr_pkg::CSR_HOLD_RESTART:    cfg_ff.hold_restart    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-key update, keys are independent
   always_comb begin
      kdlpr_pkg::history_type h;
      kdlpr_pkg::time_type    hold_a;
      kdlpr_pkg::time_type    thr_a;
      logic                   rel;
      logic                   prs;
      level_in  = level_ff;
      press_in  = '0;
      repeat_in = '0;
      for (int i = 0; i < kdlpr_pkg::NUM_KEYS; i++) begin
         h   = {hist_ff[i][kdlpr_pkg::HISTORY_BITS-2:0], req_chan.key_levels[i]};
         rel = &h;
         prs = ~|h;
         hist_in[i] = h;
         hold_a     = hold_ff[i];
         thr_a      = thr_ff[i];
         if (rel) begin
            level_in[i] = 1'b1;
            hold_a      = '0;
            thr_a       = cfg_ff.repeat_first;
         end else if (prs) begin
            level_in[i] = 1'b0;
            hold_a      = kdlpr_pkg::sat_add(hold_ff[i],
                             {{(kdlpr_pkg::TIME_BITS-kdlpr_pkg::INC_BITS){1'b0}},
                              cfg_ff.hold_increment});
         end
         press_in[i] = level_ff[i] && !level_in[i];
         if (hold_a < cfg_ff.hold_limit && thr_a < cfg_ff.hold_limit) begin
            hold_in[i] = hold_a;
            if (hold_a > thr_a) begin
               repeat_in[i] = 1'b1;
               thr_in[i]    = kdlpr_pkg::sat_add(thr_a, cfg_ff.repeat_interval);
            end else begin
               thr_in[i] = thr_a;
            end
         end else begin
            // limit reached: restart hold time and threshold
            hold_in[i] = cfg_ff.hold_restart;
            thr_in[i]  = cfg_ff.repeat_first;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '1;
         for (int i = 0; i < kdlpr_pkg::NUM_KEYS; i++) begin
            hist_ff[i] <= '1;
            hold_ff[i] <= '0;
            thr_ff[i]  <= kdlpr_pkg::REPEAT_FIRST_RESET;
         end
      end else if (req_fire) begin
         level_ff <= level_in;
         for (int i = 0; i < kdlpr_pkg::NUM_KEYS; i++) begin
            hist_ff[i] <= hist_in[i];
            hold_ff[i] <= hold_in[i];
            thr_ff[i]  <= thr_in[i];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         press_ff     <= press_in;
         repeat_ff    <= repeat_in;
         out_level_ff <= level_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.press_mask       = press_ff;
   assign rsp_chan.repeat_mask      = repeat_ff;
   assign rsp_chan.debounced_levels = out_level_ff;

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted tick did not produce a result");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("input stalled while output register empty");

   a_press_means_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (press_ff & out_level_ff) == '0)
      else $error("press event on a key that is not pressed");

   for (genvar k = 0; k < kdlpr_pkg::NUM_KEYS; k++) begin : g_chk
      a_level_needs_stable_history: assert property (@(posedge clock) disable iff (reset)
         (req_fire && level_in[k] != level_ff[k]) |->
            (hist_in[k] == {kdlpr_pkg::HISTORY_BITS{level_in[k]}}))
         else $error("debounced level changed without a settled history");
   end

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import kdlpr_pkg::*;

   localparam int unsigned TIME_MAX    = (1 << TIME_BITS) - 1;
   localparam int          STALL_LIMIT = 2000;
   localparam int          PHASE_ITEMS = 70;

   typedef struct packed {
      key_vec_type press;
      key_vec_type rep;
      key_vec_type levels;
   } tick_result_type;

   typedef struct packed {
      history_type hist;
      logic        level;
      logic        last_level;
      time_type    hold;
      time_type    thresh;
   } key_track_type;

   logic          clock;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   kdlpr_req_if req_bus ();
   kdlpr_rsp_if rsp_bus ();

   key_debounce_long_press_repeat DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cfg_type         cfg_model;
   key_track_type   key_model[NUM_KEYS];
   tick_result_type expected_ticks[$];
   int              fail_count;
   int              stall_cycles;
   bit              quiet_mode;
   bit              key_target[NUM_KEYS];
   int              run_left[NUM_KEYS];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic time_type clamp_sum(input time_type a, input time_type b);
      int unsigned total;
      total = a + b;
      return (total > TIME_MAX) ? time_type'(TIME_MAX) : time_type'(total);
   endfunction

   function automatic cfg_type make_cfg(input int unsigned inc, input int unsigned first,
                                        input int unsigned interval,
                                        input int unsigned limit,
                                        input int unsigned restart);
      cfg_type c;
      c.hold_increment  = inc_type'(inc);
      c.repeat_first    = time_type'(first);
      c.repeat_interval = time_type'(interval);
      c.hold_limit      = time_type'(limit);
      c.hold_restart    = time_type'(restart);
      return c;
   endfunction

   function automatic void reset_key_model();
      cfg_model = make_cfg(HOLD_INCREMENT_RESET, REPEAT_FIRST_RESET, REPEAT_INTERVAL_RESET,
                           HOLD_LIMIT_RESET, HOLD_RESTART_RESET);
      for (int k = 0; k < NUM_KEYS; k++) begin
         key_model[k].hist       = '1;
         key_model[k].level      = 1'b1;
         key_model[k].last_level = 1'b1;
         key_model[k].hold       = '0;
         key_model[k].thresh     = cfg_model.repeat_first;
      end
   endfunction

   // one scan tick across all keys, returns the events it causes
   function automatic tick_result_type scan_tick(input key_vec_type raw);
      tick_result_type r;
      history_type     h;
      r = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         h = {key_model[k].hist[HISTORY_BITS-2:0], raw[k]};
         key_model[k].hist = h;
         if (h == '1) begin
            key_model[k].level  = 1'b1;
            key_model[k].hold   = '0;
            key_model[k].thresh = cfg_model.repeat_first;
         end else if (h == '0) begin
            key_model[k].level = 1'b0;
            key_model[k].hold  = clamp_sum(key_model[k].hold,
                                           time_type'(cfg_model.hold_increment));
         end
         if (key_model[k].last_level != key_model[k].level) begin
            if (!key_model[k].level)
               r.press[k] = 1'b1;
            key_model[k].last_level = key_model[k].level;
         end
         if (key_model[k].hold < cfg_model.hold_limit &&
             key_model[k].thresh < cfg_model.hold_limit) begin
            if (key_model[k].hold > key_model[k].thresh) begin
               r.rep[k] = 1'b1;
               key_model[k].thresh = clamp_sum(key_model[k].thresh,
                                               cfg_model.repeat_interval);
            end
         end else begin
            key_model[k].hold   = cfg_model.hold_restart;
            key_model[k].thresh = cfg_model.repeat_first;
         end
         r.levels[k] = key_model[k].level;
      end
      return r;
   endfunction

   function automatic int idle_draw();
      return quiet_mode ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= 10)
         $display("ERROR: %s", what);
   endtask

   task automatic send_scan(input key_vec_type levels);
      int gap;
      gap = idle_draw();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.key_levels <= levels;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_ticks.push_back(scan_tick(levels));
   endtask

   // drop valid, drain all results, then idle before returning
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input csr_data_type data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic csr_release();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_config(input cfg_type c);
      wait_idle();
      csr_write(CSR_HOLD_INCREMENT, csr_data_type'(c.hold_increment));
      csr_write(CSR_REPEAT_FIRST, c.repeat_first);
      csr_write(CSR_REPEAT_INTERVAL, c.repeat_interval);
      csr_write(CSR_HOLD_LIMIT, c.hold_limit);
      csr_write(CSR_HOLD_RESTART, c.hold_restart);
      csr_release();
      cfg_model = c;
   endtask

   // keys held in runs, mostly long enough to debounce, with bounce and stray noise
   task automatic run_key_traffic(input int count);
      key_vec_type levels;
      for (int n = 0; n < count; n++) begin
         if (n % 20 == 0)
            quiet_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 19) == 0) begin
            levels = key_vec_type'($urandom);
         end else begin
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (run_left[k] == 0) begin
                  key_target[k] = ~key_target[k];
                  run_left[k] = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 7)
                                                            : $urandom_range(8, 60);
               end
               run_left[k]--;
               levels[k] = key_target[k];
               if ($urandom_range(0, 11) == 0)
                  levels[k] = ~levels[k];
            end
         end
         send_scan(levels);
      end
   endtask

   task automatic test_debounce_press();
      send_scan(4'hF);
      repeat (8) send_scan(4'h0);
   endtask

   // force a reload, then push hold time and threshold into saturation
   task automatic test_limit_saturation();
      load_config(make_cfg(255, 65000, 65535, 0, 65100));
      send_scan(4'h0);
      load_config(make_cfg(255, 65000, 65535, 65535, 65100));
      repeat (3) send_scan(4'h0);
   endtask

   task automatic test_bounce_release();
      wait_idle();
      csr_write(csr_index_type'(CSR_HOLD_RESTART + $urandom_range(1, 3)),
                csr_data_type'($urandom));
      csr_release();
      send_scan(4'b0101);
      send_scan(4'b1010);
      repeat (8) send_scan(4'hF);
   endtask

   task automatic test_fast_repeat();
      repeat (2) begin
         load_config(make_cfg($urandom_range(60, 255), $urandom_range(0, 1500),
                              $urandom_range(1, 400), $urandom_range(30000, 65535),
                              $urandom_range(0, 65535)));
         run_key_traffic(PHASE_ITEMS);
      end
   endtask

   task automatic test_low_limit();
      repeat (2) begin
         load_config(make_cfg($urandom_range(1, 255), $urandom_range(0, 5000),
                              $urandom_range(1, 2000), $urandom_range(0, 4000),
                              $urandom_range(0, 6000)));
         run_key_traffic(PHASE_ITEMS);
      end
   endtask

   task automatic test_extreme_configs();
      load_config(make_cfg(1, 0, 1, 0, 0));
      run_key_traffic(PHASE_ITEMS);
      load_config(make_cfg(255, 65535, 65535, 65535, 65535));
      run_key_traffic(PHASE_ITEMS);
      load_config(make_cfg(255, 0, 65535, 65535, 0));
      run_key_traffic(PHASE_ITEMS);
   endtask

   task automatic test_random_configs();
      load_config(make_cfg($urandom_range(1, 255), $urandom_range(0, 65535),
                           $urandom_range(1, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535)));
      run_key_traffic(PHASE_ITEMS);
      load_config(make_cfg(HOLD_INCREMENT_RESET, REPEAT_FIRST_RESET, REPEAT_INTERVAL_RESET,
                           HOLD_LIMIT_RESET, HOLD_RESTART_RESET));
      run_key_traffic(PHASE_ITEMS);
   endtask

   initial begin : receiver
      int gap;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = idle_draw();
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin : check_results
      tick_result_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_ticks.size() == 0) begin
            note_failure($sformatf("unexpected transfer: press %h repeat %h levels %h",
                                   rsp_bus.press_mask, rsp_bus.repeat_mask,
                                   rsp_bus.debounced_levels));
         end else begin
            want = expected_ticks.pop_front();
            if (rsp_bus.press_mask !== want.press || rsp_bus.repeat_mask !== want.rep ||
                rsp_bus.debounced_levels !== want.levels)
               note_failure($sformatf(
                  "tick mismatch: press %h/%h repeat %h/%h levels %h/%h (exp/got)",
                  want.press, rsp_bus.press_mask, want.rep, rsp_bus.repeat_mask,
                  want.levels, rsp_bus.debounced_levels));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("key_debounce_long_press_repeat test failed");
         $finish;
      end
   end

   initial begin
      fail_count   = 0;
      stall_cycles = 0;
      quiet_mode   = 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         key_target[k] = 1'b1;
         run_left[k]   = 0;
      end
      reset_key_model();
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_HOLD_INCREMENT;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.key_levels <= '0;
      rsp_bus.ready      <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_debounce_press();
      test_limit_saturation();
      test_bounce_release();
      test_fast_repeat();
      test_low_limit();
      test_extreme_configs();
      test_random_configs();

      wait_idle();
      if (expected_ticks.size() != 0)
         note_failure("results still outstanding at end of run");
      if (fail_count == 0)
         $display("key_debounce_long_press_repeat test passed");
      else
         $display("key_debounce_long_press_repeat test failed");
      $finish;
   end

endmodule

### sim.f
design/kdlpr_pkg.sv
design/kdlpr_req_if.sv
design/kdlpr_rsp_if.sv
design/key_debounce_long_press_repeat.sv
tb/sv/tb_top.sv
